FILE: src/olm_pkg.sv
// shared types and constants for the ordered list move block
// no dependencies
package olm_pkg;

  localparam int ID_W    = 7;   // item number width
  localparam int CNT_W   = 7;   // item count width
  localparam int OFF_W   = 7;   // signed offset width
  localparam int POS_W   = 6;   // read position width
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] ITEM_COUNT_RST = 7'd64;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             load;    // reload the list as 1..len
    logic             commit;  // apply the move this cycle
    logic             fwd;     // target after the item's position
    logic             bwd;     // target before the item's position
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] len;
  } cell_ctrl_t;

endpackage

FILE: src/olm_if.sv
// valid/ready channel interfaces for requests and results
// depends on olm_pkg
interface olm_in_if import olm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [ID_W-1:0]         item_id;
  logic signed [OFF_W-1:0] offset;
  logic [POS_W-1:0]        position;

  modport source (output valid, opcode, item_id, offset, position, input ready);
  modport sink   (input valid, opcode, item_id, offset, position, output ready);
endinterface

interface olm_out_if import olm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    item_at_position;
  logic [STAT_W-1:0]  status;

  modport source (output valid, item_at_position, status, input ready);
  modport sink   (input valid, item_at_position, status, output ready);
endinterface

FILE: src/olm_cell.sv
// one list slot: holds the item number at a fixed position
// depends on olm_pkg
module olm_cell import olm_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 6
) (
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [PW-1:0]   p,
  input  logic [PW-1:0]   q,
  input  logic [ID_W-1:0] left_val,
  input  logic [ID_W-1:0] right_val,
  output logic [ID_W-1:0] val,
  output logic            match
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  logic [ID_W-1:0] val_r, val_nxt;
  logic            active;

  assign active = (IDX < int'(ctrl.len));
  assign match  = active && (val_r == ctrl.id);
  assign val    = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      val_nxt = active ? ID_W'(IDX + 1) : '0;
    end else if (ctrl.commit) begin
      if (ctrl.fwd && MY_POS >= p && MY_POS < q) begin
        val_nxt = right_val;
      end else if (ctrl.bwd && MY_POS > q && MY_POS <= p) begin
        val_nxt = left_val;
      end else if ((ctrl.fwd || ctrl.bwd) && MY_POS == q) begin
        val_nxt = ctrl.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: src/ordered_list_move_by_offset.sv
// top level: sequencer, row of list cells, output register
// depends on olm_pkg, olm_if, olm_cell
//
// a request accepted in idle or shift passes the find state, then the shift state, where its result is registered
// a new request is taken in idle, or in shift as the previous one retires, but never in find
// a held result stalls the shift cycle, so the next request waits until it is taken
// reset (rst_n low, synchronous) reloads the list as 1..min(64, MAX_ITEMS)
// a cfg write reloads the list as 1..min(cfg_wdata, MAX_ITEMS)
module ordered_list_move_by_offset import olm_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  olm_in_if.sink           in_ch,
  olm_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int PW      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int RST_LEN = (MAX_ITEMS < 64) ? MAX_ITEMS : 64;
  // signed width for position plus offset, with room for the sign
  localparam int SW      = ((PW > OFF_W) ? PW : OFF_W) + 2;

  // sequencer state
  state_t state_r, state_nxt;

  // captured request
  logic                    op_r;
  logic [ID_W-1:0]         id_r;
  logic signed [OFF_W-1:0] off_r;
  logic [POS_W-1:0]        pos_r;

  // active list length
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cfg_len;

  // find results
  logic [PW-1:0] p_r, p_nxt;
  logic          found_r, found_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_item_r, out_item_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  // handshake and control
  logic accept;
  logic out_free;
  logic finish;
  logic in_ready_c;

  // cell row
  cell_ctrl_t      ctrl;
  logic [ID_W-1:0] cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] match;
  logic [PW-1:0]   q;
  logic signed [SW-1:0] q_s, lim_s;
  logic [ID_W-1:0] rd_val;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready_c;
  assign in_ch.ready = in_ready_c;

  // clip the written count to the number of cells
  assign cfg_len = (int'(cfg_wdata) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS) : cfg_wdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_FIND;
      end
      S_FIND: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (out_free) state_nxt = accept ? S_FIND : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state outputs: a request can enter while the previous one retires
  always_comb begin
    in_ready_c = 1'b0;
    finish     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready_c = 1'b1;
      end
      S_FIND: begin
        in_ready_c = 1'b0;
      end
      S_SHIFT: begin
        in_ready_c = out_free;
        finish     = out_free;
      end
      default: begin
        in_ready_c = 1'b0;
      end
    endcase
  end

  // find: each cell compares its item, one-hot match encodes to a position
  always_comb begin
    p_nxt     = p_r;
    found_nxt = found_r;
    if (state_r == S_FIND) begin
      p_nxt     = '0;
      found_nxt = |match;
      for (int i = 0; i < MAX_ITEMS; i++) begin
        if (match[i]) p_nxt = p_nxt | PW'(i);
      end
    end
  end

  // target position, clipped to the list ends
  always_comb begin
    q_s   = $signed({{(SW-PW){1'b0}}, p_r}) + $signed({{(SW-OFF_W){off_r[OFF_W-1]}}, off_r});
    lim_s = $signed({{(SW-CNT_W){1'b0}}, len_r}) - SW'(1);
    if (q_s < 0) begin
      q_s = '0;
    end else if (q_s > lim_s) begin
      q_s = lim_s;
    end
    q = q_s[PW-1:0];
  end

  // broadcast to the cells; reset and cfg writes reload the whole row
  always_comb begin
    ctrl.load   = !rst_n || cfg_we;
    ctrl.commit = finish && (op_r == OP_MOVE) && found_r;
    ctrl.fwd    = q > p_r;
    ctrl.bwd    = q < p_r;
    ctrl.id     = id_r;
    ctrl.len    = !rst_n ? CNT_W'(RST_LEN) : (cfg_we ? cfg_len : len_r);
  end

  assign len_nxt = ctrl.len;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      logic [ID_W-1:0] left_v, right_v;
      if (gi == 0) begin : g_head
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_val[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_tail
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_val[gi+1];
      end
      olm_cell #(
        .IDX (gi),
        .PW  (PW)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .p         (p_r),
        .q         (q),
        .left_val  (left_v),
        .right_val (right_v),
        .val       (cell_val[gi]),
        .match     (match[gi])
      );
    end
  endgenerate

  // read: select the cell at the requested position
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (i == int'(pos_r)) rd_val = rd_val | cell_val[i];
    end
  end

  // result formation in the shift cycle
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_item_nxt   = out_item_r;
    out_status_nxt = out_status_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      if (op_r == OP_MOVE) begin
        out_item_nxt   = '0;
        out_status_nxt = found_r ? STATUS_DONE : STATUS_NOT_FOUND;
      end else if ({1'b0, pos_r} < len_r) begin
        out_item_nxt   = rd_val;
        out_status_nxt = STATUS_DONE;
      end else begin
        out_item_nxt   = '0;
        out_status_nxt = STATUS_RANGE;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.item_at_position = out_item_r;
  assign out_ch.status           = out_status_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= CNT_W'(RST_LEN);
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      found_r     <= found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    out_item_r   <= out_item_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      op_r  <= in_ch.opcode;
      id_r  <= in_ch.item_id;
      off_r <= in_ch.offset;
      pos_r <= in_ch.position;
    end
  end

endmodule

FILE: src/olm_checker.sv
// port-level checks for the ordered list move block, bound to the top level
// depends on olm_pkg and ordered_list_move_by_offset
module olm_checker import olm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   out_item,
  input logic [STAT_W-1:0] out_status
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item) && $stable(out_status))
    else $error("result changed while stalled");

  // only defined status codes are produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_DONE || out_status == STATUS_NOT_FOUND ||
                   out_status == STATUS_RANGE))
    else $error("undefined status code");

  // failed requests report no item
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_DONE |-> out_item == '0)
    else $error("item reported with error status");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted request occupies the find cycle
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted during find cycle");

endmodule

bind ordered_list_move_by_offset olm_checker u_olm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_item   (out_ch.item_at_position),
  .out_status (out_ch.status)
);

FILE: sim/ordered_list_move_by_offset_tb.sv
// self-checking testbench for ordered_list_move_by_offset: a directed table, then random phases
// depends on olm_pkg, olm_if and the block's top level; keeps its own list model for prediction
module ordered_list_move_by_offset_tb import olm_pkg::*; ();

  localparam int MAX_ITEMS   = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  // one request as the sender drives it
  typedef struct packed {
    logic                    opcode;
    logic [ID_W-1:0]         item_id;
    logic signed [OFF_W-1:0] offset;
    logic [POS_W-1:0]        position;
  } list_req_t;

  // one result as the block returns it
  typedef struct packed {
    logic [ID_W-1:0]   item;
    logic [STAT_W-1:0] status;
  } list_rsp_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_SET_COUNT
  } row_kind_t;

  // a row of the directed table: a request or a count write, with an optional hand-typed result
  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] count;
    list_req_t        req;
    bit               has_typed;
    list_rsp_t        typed_rsp;
  } directed_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  olm_in_if  req_ch ();
  olm_out_if rsp_ch ();

  ordered_list_move_by_offset #(
    .MAX_ITEMS (MAX_ITEMS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted list contents and active length
  logic [ID_W-1:0] list_order [MAX_ITEMS];
  int              list_len;

  // results still owed by the block, oldest first
  list_rsp_t pending_results [$];

  int failures    = 0;
  int cycle_count = 0;
  int req_burst   = 0;
  int rsp_burst   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** ordered_list_move_by_offset: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- list model

  // reset and every count write reload the list as 1..count, count clipped to the store size
  function automatic void reload_list(input logic [CNT_W-1:0] count);
    list_len = (count > MAX_ITEMS) ? MAX_ITEMS : int'(count);
    for (int i = 0; i < MAX_ITEMS; i++)
      list_order[i] = (i < list_len) ? ID_W'(i + 1) : '0;
  endfunction

  // works out the result of one request and updates the list the way the block will
  function automatic list_rsp_t apply_to_list(input list_req_t r);
    list_rsp_t rsp;
    int        p;
    int        q;
    bit        found;
    rsp.item   = '0;
    rsp.status = STATUS_DONE;
    p          = 0;
    found      = 1'b0;
    if (r.opcode == OP_MOVE) begin
      for (int i = 0; i < list_len; i++) begin
        if (!found && list_order[i] == r.item_id) begin
          p     = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        // unknown item, including 0 and anything past the count
        rsp.status = STATUS_NOT_FOUND;
      end else begin
        // target clipped to both ends; a target equal to p leaves the order alone
        q = p + int'($signed(r.offset));
        if (q < 0) q = 0;
        if (q > list_len - 1) q = list_len - 1;
        if (q > p) begin
          for (int i = p; i < q; i++) list_order[i] = list_order[i + 1];
          list_order[q] = r.item_id;
        end else if (q < p) begin
          for (int i = p; i > q; i--) list_order[i] = list_order[i - 1];
          list_order[q] = r.item_id;
        end
      end
    end else if (int'(r.position) < list_len) begin
      rsp.item = list_order[r.position];
    end else begin
      rsp.status = STATUS_RANGE;
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // per-request wait: mostly a random gap, with occasional bursts of back-to-back traffic
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic directed_row_t move_row(input int id, input int off);
    directed_row_t row;
    row.kind             = ROW_REQUEST;
    row.count            = '0;
    row.req.opcode       = OP_MOVE;
    row.req.item_id      = id[ID_W-1:0];
    row.req.offset       = off[OFF_W-1:0];
    row.req.position     = POS_W'($urandom);
    row.has_typed        = 1'b0;
    row.typed_rsp        = '0;
    return row;
  endfunction

  function automatic directed_row_t read_row(input int pos);
    directed_row_t row;
    row.kind             = ROW_REQUEST;
    row.count            = '0;
    row.req.opcode       = OP_READ;
    row.req.item_id      = ID_W'($urandom);
    row.req.offset       = OFF_W'($urandom);
    row.req.position     = pos[POS_W-1:0];
    row.has_typed        = 1'b0;
    row.typed_rsp        = '0;
    return row;
  endfunction

  function automatic directed_row_t count_row(input int count);
    directed_row_t row;
    row.kind      = ROW_SET_COUNT;
    row.count     = count[CNT_W-1:0];
    row.req       = '0;
    row.has_typed = 1'b0;
    row.typed_rsp = '0;
    return row;
  endfunction

  // attaches a hand-typed result to a row
  function automatic directed_row_t with_result(input directed_row_t row, input int item,
                                                input logic [STAT_W-1:0] status);
    row.has_typed        = 1'b1;
    row.typed_rsp.item   = item[ID_W-1:0];
    row.typed_rsp.status = status;
    return row;
  endfunction

  // random request; mostly items and positions that exist so moves actually reshuffle
  function automatic list_req_t random_request();
    list_req_t r;
    r.item_id  = ID_W'($urandom);
    r.offset   = OFF_W'($urandom);
    r.position = POS_W'($urandom);
    if ($urandom_range(0, 99) < 55) begin
      r.opcode = OP_MOVE;
      if (list_len > 0 && $urandom_range(0, 9) != 0)
        r.item_id = ID_W'($urandom_range(1, list_len));
      case ($urandom_range(0, 9))
        0: r.offset = '0;
        1, 2, 3: r.offset = OFF_W'(int'($urandom_range(0, 8)) - 4);
        default: r.offset = OFF_W'($urandom);
      endcase
    end else begin
      r.opcode = OP_READ;
      if (list_len > 0 && $urandom_range(0, 4) != 0)
        r.position = POS_W'($urandom_range(0, list_len - 1));
    end
    return r;
  endfunction

  // offers one request after a random gap, then records what it should produce
  task automatic send_request(input list_req_t r, input bit has_typed,
                              input list_rsp_t typed_rsp);
    int        gap;
    list_rsp_t predicted;
    gap = draw_wait(req_burst);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.opcode   = r.opcode;
    req_ch.item_id  = r.item_id;
    req_ch.offset   = r.offset;
    req_ch.position = r.position;
    req_ch.valid    = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    // the list model must advance even where the result is typed by hand
    predicted = apply_to_list(r);
    pending_results.push_back(has_typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // count writes only with the block idle: every request gives exactly one result,
  // so an empty expectation queue means nothing is in flight
  task automatic write_count(input logic [CNT_W-1:0] count);
    req_ch.valid = 1'b0;
    wait_for_drain();
    cfg_we    = 1'b1;
    cfg_wdata = count;
    @(negedge clk);
    cfg_we = 1'b0;
    reload_list(count);
  endtask

  // ---------------------------------------------------------------- request side

  initial begin
    directed_row_t    directed_rows [$];
    logic [CNT_W-1:0] phase_counts [8];
    int               phase_items;

    rst_n           = 1'b0;
    clk             = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_MOVE;
    req_ch.item_id  = '0;
    req_ch.offset   = '0;
    req_ch.position = '0;
    reload_list(ITEM_COUNT_RST);

    directed_rows = '{
      // list 1..64 after reset
      with_result(read_row(0), 1, STATUS_DONE),
      with_result(read_row(63), 64, STATUS_DONE),
      // unknown items: zero, just past the list, all ones
      with_result(move_row(0, 5), 0, STATUS_NOT_FOUND),
      with_result(move_row(65, -3), 0, STATUS_NOT_FOUND),
      with_result(move_row(127, -1), 0, STATUS_NOT_FOUND),
      // zero offset and moves clipped back onto the item itself
      with_result(move_row(1, 0), 0, STATUS_DONE),
      with_result(move_row(1, -64), 0, STATUS_DONE),
      with_result(move_row(64, 63), 0, STATUS_DONE),
      with_result(read_row(0), 1, STATUS_DONE),
      // real moves: head to tail, tail to head, mid-list both ways
      move_row(1, 63),
      read_row(63),
      move_row(64, -64),
      read_row(0),
      move_row(10, 5),
      read_row(14),
      move_row(30, -7),
      read_row(22),
      // empty list
      count_row(0),
      with_result(move_row(1, 1), 0, STATUS_NOT_FOUND),
      with_result(read_row(0), 0, STATUS_RANGE),
      // count above the store size is clipped
      count_row(127),
      with_result(read_row(63), 64, STATUS_DONE),
      // single item: any move lands on itself
      count_row(1),
      with_result(move_row(1, 63), 0, STATUS_DONE),
      with_result(read_row(1), 0, STATUS_RANGE),
      with_result(read_row(0), 1, STATUS_DONE),
      count_row(2),
      move_row(1, 1),
      read_row(0)
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SET_COUNT)
        write_count(directed_rows[i].count);
      else
        send_request(directed_rows[i].req, directed_rows[i].has_typed,
                     directed_rows[i].typed_rsp);
    end

    // random phases across the count range, extremes included
    phase_counts = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127,
                     CNT_W'($urandom_range(3, 63)), CNT_W'($urandom_range(3, 63)), 7'd64};
    foreach (phase_counts[ph]) begin
      write_count(phase_counts[ph]);
      // an empty list only gives error results, so it gets a short phase
      phase_items = (phase_counts[ph] == 0) ? 24 : 97;
      repeat (phase_items) send_request(random_request(), 1'b0, '0);
    end

    req_ch.valid = 1'b0;
    wait_for_drain();
    // catch any stray result
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("** ordered_list_move_by_offset: PASSED **");
    else
      $display("** ordered_list_move_by_offset: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  initial begin
    int        gap;
    list_rsp_t want;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_wait(rsp_burst);
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("result with none expected: item_at_position %0d, status %0d",
               rsp_ch.item_at_position, rsp_ch.status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.item_at_position !== want.item) begin
          $error("item_at_position: expected %0d, got %0d", want.item, rsp_ch.item_at_position);
          failures++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          failures++;
        end
      end
      @(negedge clk);
    end
  end

endmodule
